/* design/bifs_pkg.sv */
// shared types, codes and a helper function for the bitmap free-bit search block
package bifs_pkg;

  localparam int MODE_W   = 2;
  localparam int WIDX_W   = 10;
  localparam int WORD_W   = 64;
  localparam int START_W  = 16;
  localparam int LEN_W    = 17;
  localparam int OFFSET_W = 16;
  localparam int COUNT_W  = 17;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [PADDR_W-1:0] REG_BIT_LIMIT = 3'd0;

  localparam logic [COUNT_W-1:0] BIT_LIMIT_RST  = 17'h10000;
  localparam logic [LEN_W-1:0]   MAX_SEARCH_LEN = 17'h10000;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [WIDX_W-1:0]   word_index;
    logic [WORD_W-1:0]   word_data;
    logic [START_W-1:0]  start_index;
    logic [LEN_W-1:0]    span_len;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic clearing;
  } stat_t;

  // index of the lowest set bit, v must be nonzero
  function automatic logic [5:0] lowest_bit(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    logic [5:0]        n;
    t = v;
    n = '0;
    if (t[31:0] == '0) begin
      n[5] = 1'b1;
      t = t >> 32;
    end
    if (t[15:0] == '0) begin
      n[4] = 1'b1;
      t = t >> 16;
    end
    if (t[7:0] == '0) begin
      n[3] = 1'b1;
      t = t >> 8;
    end
    if (t[3:0] == '0) begin
      n[2] = 1'b1;
      t = t >> 4;
    end
    if (t[1:0] == '0) begin
      n[1] = 1'b1;
      t = t >> 2;
    end
    if (t[0] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

/* design/bifs_if.sv */
// valid/ready channel interfaces for command and result beats
interface bifs_in_if;
  logic                              valid;
  logic                              ready;
  logic [bifs_pkg::MODE_W-1:0]       mode;
  logic [bifs_pkg::WIDX_W-1:0]       word_index;
  logic [bifs_pkg::WORD_W-1:0]       word_data;
  logic [bifs_pkg::START_W-1:0]      start_index;
  logic [bifs_pkg::LEN_W-1:0]        span_len;

  modport source (
    output valid, mode, word_index, word_data, start_index, span_len,
    input  ready
  );
  modport sink (
    input  valid, mode, word_index, word_data, start_index, span_len,
    output ready
  );
endinterface

interface bifs_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [bifs_pkg::OFFSET_W-1:0]     offset;

  modport source (
    output valid, found, offset,
    input  ready
  );
  modport sink (
    input  valid, found, offset,
    output ready
  );
endinterface

/* design/bifs_ram.sv */
// single-write, single-read bitmap word memory with registered read data
module bifs_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [bifs_pkg::WORD_W-1:0]   wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [bifs_pkg::WORD_W-1:0]   rdata
);
  import bifs_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/bifs_search.sv */
// command sequencer: word writes, clearing sweep and word-by-word free-bit scan
module bifs_search #(
  parameter int BITMAP_WORDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bifs_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output bifs_pkg::rsp_t                rsp,
  input  logic [bifs_pkg::COUNT_W-1:0]  bit_limit,
  output bifs_pkg::stat_t               stat
);
  import bifs_pkg::*;

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam logic [22:0]   CAP      = 23'(BITMAP_WORDS * 64);
  localparam logic [AW-1:0] LAST_ROW = AW'(BITMAP_WORDS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FOUND = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;
  localparam logic [2:0] ST_CLEAR = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                clr_resp_r, clr_resp_nxt;
  logic                rsp_valid_r, rsp_valid_nxt;
  logic [START_W-1:0]  start_r, start_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    last_r, last_nxt;
  logic [10:0]         cw_r, cw_nxt;
  logic [WORD_W-1:0]   bits_r, bits_nxt;
  logic [LEN_W-1:0]    pos_r, pos_nxt;
  logic                hit_r, hit_nxt;
  rsp_t                rsp_r, rsp_nxt;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [WORD_W-1:0]   wdata;
  logic                re;
  logic [AW-1:0]       raddr;
  logic [WORD_W-1:0]   rdata;

  logic [COUNT_W-1:0]  cap;
  logic [LEN_W-1:0]    rem;
  logic [LEN_W-1:0]    len_clip;
  logic                empty;
  logic [10:0]         w0;
  logic [10:0]         w1;
  logic [WORD_W-1:0]   lo_mask;
  logic [WORD_W-1:0]   hi_mask;
  logic [WORD_W-1:0]   masked;

  bifs_ram #(
    .DEPTH (BITMAP_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req_ready = (state_r == ST_IDLE);
  assign rsp_valid = rsp_valid_r;
  assign rsp       = rsp_r;
  assign stat      = '{idle: (state_r == ST_IDLE), clearing: (state_r == ST_CLEAR)};

  // effective bit limit is the smaller of the register and the storage size
  assign cap   = ({6'd0, bit_limit} < CAP) ? bit_limit : CAP[COUNT_W-1:0];
  assign rem   = cap - {1'b0, start_r};
  assign empty = (len_r == '0) || ({1'b0, start_r} >= cap);

  always_comb begin
    len_clip = len_r;
    if (len_clip > rem) begin
      len_clip = rem;
    end
    if (len_clip > MAX_SEARCH_LEN) begin
      len_clip = MAX_SEARCH_LEN;
    end
  end

  assign w0      = {1'b0, start_r[15:6]};
  assign w1      = last_r[16:6];
  assign lo_mask = (cw_r == w0) ? ({WORD_W{1'b1}} << start_r[5:0]) : {WORD_W{1'b1}};
  assign hi_mask = (cw_r == w1) ? ({WORD_W{1'b1}} >> (6'd63 - last_r[5:0]))
                                : {WORD_W{1'b1}};
  assign masked  = rdata & lo_mask & hi_mask;

  // reads happen only during a scan and writes only outside it, so the fsm
  // itself keeps accesses to one entry from overlapping
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_resp_nxt  = clr_resp_r;
    rsp_valid_nxt = rsp_valid_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    last_nxt      = last_r;
    cw_nxt        = cw_r;
    bits_nxt      = bits_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    rsp_nxt       = rsp_r;
    we            = 1'b0;
    waddr         = AW'(req.word_index);
    wdata         = req.word_data;
    re            = 1'b0;
    raddr         = AW'(cw_r);

    if (rsp_valid_r && rsp_ready) begin
      rsp_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          hit_nxt = 1'b0;
          case (req.mode)
            MODE_WRITE: begin
              we        = (int'(req.word_index) < BITMAP_WORDS);
              state_nxt = ST_RESP;
            end
            MODE_FIND: begin
              start_nxt = req.start_index;
              len_nxt   = req.span_len;
              state_nxt = ST_PREP;
            end
            MODE_CLEAR: begin
              clr_cnt_nxt  = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_PREP: begin
        if (empty) begin
          state_nxt = ST_RESP;
        end else begin
          len_nxt   = len_clip;
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        last_nxt  = {1'b0, start_r} + len_r - 17'd1;
        re        = 1'b1;
        raddr     = AW'(w0);
        cw_nxt    = w0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (masked != '0) begin
          bits_nxt  = masked;
          state_nxt = ST_FOUND;
        end else if (cw_r == w1) begin
          state_nxt = ST_RESP;
        end else begin
          re     = 1'b1;
          raddr  = AW'(cw_r + 11'd1);
          cw_nxt = cw_r + 11'd1;
        end
      end
      ST_FOUND: begin
        pos_nxt   = {cw_r, lowest_bit(bits_r)};
        hit_nxt   = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!rsp_valid_r || rsp_ready) begin
          rsp_valid_nxt  = 1'b1;
          rsp_nxt.found  = hit_r;
          rsp_nxt.offset = hit_r ? OFFSET_W'(pos_r - {1'b0, start_r}) : '0;
          state_nxt      = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        wdata = '0;
        if (clr_cnt_r == LAST_ROW) begin
          hit_nxt   = 1'b0;
          state_nxt = clr_resp_r ? ST_RESP : ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_resp_r  <= 1'b0;
      rsp_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_resp_r  <= clr_resp_nxt;
      rsp_valid_r <= rsp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
    last_r  <= last_nxt;
    cw_r    <= cw_nxt;
    bits_r  <= bits_nxt;
    pos_r   <= pos_nxt;
    hit_r   <= hit_nxt;
    rsp_r   <= rsp_nxt;
  end

endmodule

/* design/bitmap_interval_free_search_top.sv */
// write and unused beats go straight to the result, a clear beat after its sweep of the map
// find: an empty interval skips the map, else words are read in turn to a hit or the end
// one beat in flight, the next taken as the previous result is registered
// after reset a clearing pass over every word runs, no beat is taken
// meanwhile, and the bit limit register resets to 65536
module bitmap_interval_free_search_top #(
  parameter int BITMAP_WORDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bifs_in_if.sink                       in_bus,
  bifs_out_if.source                    out_bus,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bifs_pkg::PADDR_W-1:0]  paddr,
  input  logic [bifs_pkg::PDATA_W-1:0]  pwdata,
  output logic [bifs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import bifs_pkg::*;

  logic [COUNT_W-1:0] bit_limit_r;
  logic               reg_sel;
  logic               in_ready;
  logic               out_valid;
  req_t               req;
  rsp_t               rsp;
  stat_t              stat;

  // registers are word aligned, so the low address bits do not decode
  assign reg_sel = ({paddr[PADDR_W-1:2], 2'b00} == REG_BIT_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? PDATA_W'(bit_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_limit_r <= BIT_LIMIT_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      bit_limit_r <= pwdata[COUNT_W-1:0];
    end
  end

  assign req = '{mode:        in_bus.mode,
                 word_index:  in_bus.word_index,
                 word_data:   in_bus.word_data,
                 start_index: in_bus.start_index,
                 span_len:    in_bus.span_len};

  bifs_search #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_bus.valid),
    .req_ready   (in_ready),
    .req         (req),
    .rsp_valid   (out_valid),
    .rsp_ready   (out_bus.ready),
    .rsp         (rsp),
    .bit_limit   (bit_limit_r),
    .stat        (stat)
  );

  assign in_bus.ready   = in_ready;
  assign out_bus.valid  = out_valid;
  assign out_bus.found  = rsp.found;
  assign out_bus.offset = rsp.offset;

  a_no_accept_while_clearing : assert property (
    @(posedge clk) disable iff (!rst_n) stat.clearing |-> !in_ready
  ) else $error("input taken during clearing sweep");

  a_one_beat_in_flight : assert property (
    @(posedge clk) disable iff (!rst_n) (in_bus.valid && in_ready) |=> !in_ready
  ) else $error("second beat accepted while one is in flight");

  a_ready_only_when_idle : assert property (
    @(posedge clk) disable iff (!rst_n) in_ready |-> stat.idle
  ) else $error("ready raised outside idle");

  a_offset_zero_when_missed : assert property (
    @(posedge clk) disable iff (!rst_n) (out_valid && !rsp.found) |-> (rsp.offset == '0)
  ) else $error("nonzero offset on a not-found result");

endmodule

/* tb/tb.sv */
// self-checking testbench for the bitmap free-bit search block
module tb;
  import bifs_pkg::*;

  localparam int BITMAP_WORDS = 1024;
  localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] NOREG_ADDR  = 3'd4;
  localparam bit [WORD_W-1:0]    ALL_ONES    = '1;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 4;
  localparam int END_SETTLE   = 1100;
  // slowest beat is a full-map scan or a clear, plus gaps, hold and reset clearing
  localparam int STALL_LIMIT  = 12000;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bifs_in_if  in_bus ();
  bifs_out_if out_bus ();

  bitmap_interval_free_search_top #(.BITMAP_WORDS(BITMAP_WORDS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the map and the entry count register
  bit [WORD_W-1:0]  bitmap_copy [BITMAP_WORDS];
  logic [COUNT_W-1:0] entry_limit;
  rsp_t pending_answers [$];

  int errors;
  int n_beats, n_finds, n_found, n_clears, n_writes, n_reg_writes;
  bit burst;
  bit rx_quiet;
  bit hold_req;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // lowest free bit in [start, start+len) clipped to the entry count and storage
  function automatic rsp_t search_free(input int unsigned start, input int unsigned len);
    rsp_t r;
    int unsigned cap, n, last, w0, w1;
    bit [WORD_W-1:0] msk, bits;
    r = '0;
    cap = BITMAP_WORDS * 64;
    if (entry_limit < cap) cap = entry_limit;
    n = len;
    if (n == 0 || start >= cap) return r;
    if (n > cap - start) n = cap - start;
    if (n > 65536) n = 65536;
    last = start + n - 1;
    w0 = start >> 6;
    w1 = last >> 6;
    for (int unsigned w = w0; w <= w1; w++) begin
      msk = ALL_ONES;
      if (w == w0) msk = msk & (ALL_ONES << (start % 64));
      if (w == w1) msk = msk & (ALL_ONES >> (63 - (last % 64)));
      bits = bitmap_copy[w] & msk;
      if (bits != '0) begin
        for (int b = 0; b < 64; b++) begin
          if (bits[b]) begin
            r.found = 1'b1;
            r.offset = OFFSET_W'(w * 64 + b - start);
            return r;
          end
        end
      end
    end
    return r;
  endfunction

  // applies one beat to the shadow map and returns its answer
  function automatic rsp_t expected_answer(input req_t r);
    rsp_t a;
    a = '0;
    case (r.mode)
      MODE_WRITE: begin
        if (r.word_index < BITMAP_WORDS) bitmap_copy[r.word_index] = r.word_data;
      end
      MODE_FIND: a = search_free(r.start_index, r.span_len);
      MODE_CLEAR: begin
        foreach (bitmap_copy[i]) bitmap_copy[i] = '0;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic req_t write_item(input int idx, input bit [WORD_W-1:0] data);
    req_t r;
    r.mode = MODE_WRITE;
    r.word_index = WIDX_W'(idx);
    r.word_data = data;
    r.start_index = START_W'($urandom);
    r.span_len = LEN_W'($urandom);
    return r;
  endfunction

  function automatic req_t find_item(input int unsigned start, input int unsigned len);
    req_t r;
    r.mode = MODE_FIND;
    r.word_index = WIDX_W'($urandom);
    r.word_data = {$urandom, $urandom};
    r.start_index = START_W'(start);
    r.span_len = LEN_W'(len);
    return r;
  endfunction

  function automatic req_t plain_item(input logic [MODE_W-1:0] m);
    req_t r;
    r.mode = m;
    r.word_index = WIDX_W'($urandom);
    r.word_data = {$urandom, $urandom};
    r.start_index = START_W'($urandom);
    r.span_len = LEN_W'($urandom);
    return r;
  endfunction

  function automatic bit [WORD_W-1:0] random_word();
    bit [WORD_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = ALL_ONES;
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic send_item(input req_t r);
    int gap;
    rsp_t a;
    gap = burst ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.mode <= r.mode;
    in_bus.word_index <= r.word_index;
    in_bus.word_data <= r.word_data;
    in_bus.start_index <= r.start_index;
    in_bus.span_len <= r.span_len;
    in_bus.valid <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    a = expected_answer(r);
    pending_answers.push_back(a);
    n_beats++;
    if (r.mode == MODE_FIND) n_finds++;
    if (r.mode == MODE_CLEAR) n_clears++;
    if (r.mode == MODE_WRITE) n_writes++;
    if (a.found) n_found++;
  endtask

  // drop valid and wait until every answer has come back
  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] exp_rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_BIT_LIMIT) entry_limit = data[COUNT_W-1:0];
    n_reg_writes++;
    @(negedge clk);
    // read back while the address is still on the bus
    exp_rd = (addr == REG_BIT_LIMIT) ? PDATA_W'(entry_limit) : '0;
    if (prdata !== exp_rd) begin
      $error("prdata: expected %0d, got %0d", exp_rd, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // result side: random stalls, an optional long hold, compare against the oldest answer
  initial begin
    int stall;
    rsp_t want;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      if (pending_answers.size() == 0) begin
        $error("result beat with nothing pending: found %0d offset %0d",
               out_bus.found, out_bus.offset);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (out_bus.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_bus.found);
          errors++;
        end
        if (out_bus.offset !== want.offset) begin
          $error("offset: expected %0d, got %0d", want.offset, out_bus.offset);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_cleared_map();
    send_item(find_item(0, 65536));
    send_item(find_item(65535, 1));
    drain();
  endtask

  task automatic test_word_boundaries();
    send_item(write_item(0, 64'h8000_0000_0000_0001));
    send_item(write_item(1023, ALL_ONES));
    send_item(write_item(10'h155, 64'h0));
    send_item(write_item(10'h2AA, 64'h0000_0001_0000_0000));
    send_item(find_item(0, 1));
    send_item(find_item(1, 62));
    send_item(find_item(1, 63));
    send_item(find_item(63, 2));
    // empty interval
    send_item(find_item(0, 0));
    send_item(find_item(65535, 65536));
    send_item(find_item(65472, 1));
    // long interval, saturated at the end of the map
    send_item(find_item(64, 65536));
    drain();
  endtask

  task automatic test_entry_count_edges();
    write_register(REG_BIT_LIMIT, 32'd65472);
    send_item(write_item(1022, 64'h8000_0000_0000_0000));
    // start at and past the entry count
    send_item(find_item(65472, 10));
    send_item(find_item(65500, 1));
    send_item(find_item(65400, 65536));
    send_item(find_item(65471, 1));
    drain();
    write_register(REG_BIT_LIMIT, 32'd0);
    send_item(find_item(0, 1));
    send_item(find_item(0, 65536));
    drain();
    // beyond storage, upper data bits ignored
    write_register(REG_BIT_LIMIT, 32'hFFFF_FFFF);
    send_item(find_item(65535, 1));
    drain();
    // no register at this index
    write_register(NOREG_ADDR, 32'd1);
    send_item(find_item(65535, 1));
    drain();
    write_register(REG_BIT_LIMIT, 32'd1);
    send_item(find_item(0, 65536));
    send_item(find_item(1, 5));
    drain();
    write_register(REG_BIT_LIMIT, 32'd65536);
  endtask

  task automatic test_other_modes();
    send_item(plain_item(MODE_UNUSED));
    send_item(find_item(65535, 1));
    send_item(plain_item(MODE_CLEAR));
    send_item(find_item(0, 65536));
    send_item(find_item(65535, 1));
    drain();
  endtask

  // mostly writes and finds around one region of the map, some noise elsewhere
  task automatic run_traffic(input int count, input int base_word);
    int roll, idx;
    int unsigned start, len;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        idx = base_word + $urandom_range(0, 16);
        if (idx > BITMAP_WORDS - 1) idx = BITMAP_WORDS - 1;
        send_item(write_item(idx, random_word()));
      end else if (roll < 93) begin
        if ($urandom_range(0, 9) == 0) start = $urandom_range(0, 65535);
        else start = (base_word * 64 + $urandom_range(0, 1100)) % 65536;
        case ($urandom_range(0, 19))
          0, 1: len = $urandom_range(0, 1);
          2: len = $urandom_range(1024, 65536);
          3, 4, 5, 6, 7: len = $urandom_range(0, 1100);
          default: len = $urandom_range(0, 128);
        endcase
        send_item(find_item(start, len));
      end else if (roll < 95) begin
        send_item(plain_item(MODE_UNUSED));
      end else if (roll < 97) begin
        send_item(plain_item(MODE_CLEAR));
      end else begin
        send_item(write_item($urandom_range(0, BITMAP_WORDS - 1), random_word()));
      end
    end
  endtask

  task automatic test_random_traffic();
    int base_word, count;
    logic [COUNT_W-1:0] cnt;
    for (int p = 0; p < 7; p++) begin
      base_word = $urandom_range(0, BITMAP_WORDS - 16);
      count = 175;
      case (p)
        0: cnt = 17'd65536;
        1: cnt = 17'h1FFFF;
        2: cnt = COUNT_W'(base_word * 64 + $urandom_range(0, 1023));
        3: begin
          cnt = 17'd0;
          count = 60;
        end
        4: begin
          base_word = 0;
          cnt = COUNT_W'($urandom_range(1, 64));
        end
        5: cnt = COUNT_W'($urandom_range(0, 131071));
        default: cnt = 17'd65535;
      endcase
      // no idling on either side in the last phase
      rx_quiet = (p == 6);
      burst = (p == 6);
      write_register(REG_BIT_LIMIT, {PDATA_W'($urandom) & 32'hFFFE_0000} | PDATA_W'(cnt));
      run_traffic(count, base_word);
      drain();
      rx_quiet = 1'b0;
      burst = 1'b0;
    end
    write_register(REG_BIT_LIMIT, 32'd65536);
  endtask

  task automatic test_backpressure();
    int base_word;
    base_word = $urandom_range(0, BITMAP_WORDS - 16);
    burst = 1'b1;
    hold_req = 1'b1;
    run_traffic(60, base_word);
    burst = 1'b0;
    // sender waits for every answer before going on
    drain();
    run_traffic(40, base_word);
    drain();
  endtask

  initial begin
    errors = 0;
    n_beats = 0;
    n_finds = 0;
    n_found = 0;
    n_clears = 0;
    n_writes = 0;
    n_reg_writes = 0;
    burst = 1'b0;
    rx_quiet = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    foreach (bitmap_copy[i]) bitmap_copy[i] = '0;
    entry_limit = BIT_LIMIT_RST;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_WRITE;
    in_bus.word_index = '0;
    in_bus.word_data = '0;
    in_bus.start_index = '0;
    in_bus.span_len = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_cleared_map();
    test_word_boundaries();
    test_entry_count_edges();
    test_other_modes();
    test_random_traffic();
    test_backpressure();

    drain();
    repeat (END_SETTLE) @(posedge clk);
    $display("run covered %0d beats: %0d finds (%0d hits), %0d word writes, %0d clears",
             n_beats, n_finds, n_found, n_writes, n_clears);
    $display("entry count changed over %0d register writes, with a long result hold-off",
             n_reg_writes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
